/* rtl/core/bcde_pkg.sv */
// shared constants, types and helpers for the bcd date to epoch seconds converter
package bcde_pkg;

  localparam int unsigned YEAR_BASE_DEF  = 68;
  localparam int unsigned FIRST_YEAR     = 70;
  localparam int unsigned DAYS_PER_YEAR  = 365;
  localparam int unsigned SECS_PER_DAY   = 24 * 60 * 60;
  localparam int unsigned SECS_PER_HOUR  = 3600;
  localparam int unsigned SECS_PER_MIN   = 60;
  // leap years counted before the first epoch year
  localparam int unsigned LEAPS_BEFORE   = (FIRST_YEAR - 1) / 4;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned YEAR_W  = 9;   // decoded year plus base, up to 233 with the default base
  localparam int unsigned DAYS_W  = 17;  // day count, below 2^17
  localparam int unsigned TOD_W   = 20;  // time of day in seconds, below 2^20
  localparam int unsigned EPOCH_W = 32;

  localparam logic [3:0] MONTH_MAX = 4'd12;
  localparam logic [4:0] DAY_MAX   = 5'd31;

  typedef struct packed {
    logic [DAYS_W-1:0] days;
    logic [TOD_W-1:0]  tod;
    logic              bad;
  } bcde_mid_t;

  // two digits, no digit check: high nibble times ten plus low nibble
  function automatic logic [BYTE_W-1:0] bcd_decode(input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] hi;
    logic [BYTE_W-1:0] lo;
    hi = {4'b0000, b[7:4]};
    lo = {4'b0000, b[3:0]};
    return (hi << 3) + (hi << 1) + lo;
  endfunction

  // days before the first of each month in a common year
  function automatic logic [8:0] month_start(input logic [3:0] idx);
    logic [8:0] v;
    case (idx)
      4'd0:    v = 9'd0;
      4'd1:    v = 9'd31;
      4'd2:    v = 9'd59;
      4'd3:    v = 9'd90;
      4'd4:    v = 9'd120;
      4'd5:    v = 9'd151;
      4'd6:    v = 9'd181;
      4'd7:    v = 9'd212;
      4'd8:    v = 9'd243;
      4'd9:    v = 9'd273;
      4'd10:   v = 9'd304;
      4'd11:   v = 9'd334;
      default: v = 9'd0;
    endcase
    return v;
  endfunction

endpackage

/* rtl/core/bcde_day_count.sv */
// decode of the bcd fields, date check, day count and time of day
module bcde_day_count #(
  parameter int unsigned YEAR_BASE = bcde_pkg::YEAR_BASE_DEF
) (
  input  logic [7:0]          bcd_second,
  input  logic [7:0]          bcd_minute,
  input  logic [7:0]          bcd_hour,
  input  logic [7:0]          bcd_day,
  input  logic [7:0]          bcd_month,
  input  logic [7:0]          bcd_year,
  output bcde_pkg::bcde_mid_t mid
);

  localparam int unsigned DW = bcde_pkg::DAYS_W;
  localparam int unsigned TW = bcde_pkg::TOD_W;
  localparam int unsigned YW = bcde_pkg::YEAR_W;

  logic [7:0]    sec;
  logic [7:0]    mnt;
  logic [7:0]    hr;
  logic [7:0]    dy;
  logic [7:0]    mon;
  logic [YW-1:0] year;
  logic [YW-1:0] year_off;
  logic [YW-1:0] year_m1;
  logic [3:0]    mon_idx;
  logic          leap_extra;
  logic [DW-1:0] leap_ct;

  always_comb begin
    sec  = bcde_pkg::bcd_decode(bcd_second);
    mnt  = bcde_pkg::bcd_decode(bcd_minute);
    hr   = bcde_pkg::bcd_decode(bcd_hour);
    dy   = bcde_pkg::bcd_decode(bcd_day);
    mon  = bcde_pkg::bcd_decode(bcd_month);
    year = {1'b0, bcde_pkg::bcd_decode(bcd_year)} + YW'(YEAR_BASE);

    mid.bad = (year < YW'(bcde_pkg::FIRST_YEAR)) || (mon == 8'd0) ||
              (mon > {4'b0000, bcde_pkg::MONTH_MAX}) || (dy == 8'd0) ||
              (dy > {3'b000, bcde_pkg::DAY_MAX});

    // values below only matter when the date passes the check
    year_off   = year - YW'(bcde_pkg::FIRST_YEAR);
    year_m1    = year - YW'(1);
    leap_ct    = DW'(year_m1 >> 2) - DW'(bcde_pkg::LEAPS_BEFORE);
    mon_idx    = 4'(mon - 8'd1);
    leap_extra = (year[1:0] == 2'b00) && (mon > 8'd2);

    mid.days = DW'(year_off) * DW'(bcde_pkg::DAYS_PER_YEAR) + leap_ct
             + DW'(bcde_pkg::month_start(mon_idx)) + DW'(dy) - DW'(1)
             + DW'(leap_extra);

    mid.tod = TW'(hr) * TW'(bcde_pkg::SECS_PER_HOUR)
            + TW'(mnt) * TW'(bcde_pkg::SECS_PER_MIN) + TW'(sec);
  end

endmodule

/* rtl/core/bcd_date_to_epoch_seconds_top.sv */
// top level of the bcd calendar date to epoch seconds converter
//
// converts six raw bcd bytes from a calendar clock into seconds since
// 1 january 1970 as an unsigned 32-bit count
// input channel: in_tdata carries second, minute, hour, day, month, year,
// one byte each from the lowest bit up; an item moves when tvalid and
// tready are both high
// result channel: out_tdata holds epoch seconds, out_tuser the bad-date
// flag; a rejected date (year below 70, month outside 1..12, day outside
// 1..31) gives seconds 0 with the flag set
// pipeline: input register, day-count register, result register; an accepted
// item passes through them in that order
// throughput: one item per cycle while out_tready stays high, set by the three-register
// pipeline where each stage holds one item and moves whenever the next stage frees up
// stall: when out_tready is low the result register holds its item, the
// earlier stages keep filling, and in_tready drops once all three are full
// reset: all stages are emptied, no result is pending, in_tready rises
module bcd_date_to_epoch_seconds_top #(
  parameter int unsigned YEAR_BASE = bcde_pkg::YEAR_BASE_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // bcd_second, bcd_minute, bcd_hour, bcd_day, bcd_month, bcd_year
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // epoch_seconds
  output logic [0:0]  out_tuser   // bad_date
);

  localparam int unsigned EW = bcde_pkg::EPOCH_W;
  localparam int unsigned PW = bcde_pkg::DAYS_W + bcde_pkg::DAYS_W;

  // stage valid bits
  logic i_valid_r, i_valid_nxt;
  logic m_valid_r, m_valid_nxt;
  logic o_valid_r, o_valid_nxt;

  // stage payloads
  logic [47:0]         i_data_r;
  bcde_pkg::bcde_mid_t m_data_r;
  bcde_pkg::bcde_mid_t m_calc;
  logic [EW-1:0]       o_epoch_r, o_epoch_nxt;
  logic                o_bad_r;

  logic i_load, m_load, o_load;
  logic [PW-1:0] day_secs;

  // stage advance, driven back from the result side
  assign o_load    = m_valid_r && (!o_valid_r || out_tready);
  assign m_load    = i_valid_r && (!m_valid_r || o_load);
  assign in_tready = !i_valid_r || m_load;
  assign i_load    = in_tvalid && in_tready;

  always_comb begin
    i_valid_nxt = i_load ? 1'b1 : (m_load ? 1'b0 : i_valid_r);
    m_valid_nxt = m_load ? 1'b1 : (o_load ? 1'b0 : m_valid_r);
    o_valid_nxt = o_load ? 1'b1 : ((out_tready) ? 1'b0 : o_valid_r);
  end

  bcde_day_count #(
    .YEAR_BASE (YEAR_BASE)
  ) u_day_count (
    .bcd_second (i_data_r[7:0]),
    .bcd_minute (i_data_r[15:8]),
    .bcd_hour   (i_data_r[23:16]),
    .bcd_day    (i_data_r[31:24]),
    .bcd_month  (i_data_r[39:32]),
    .bcd_year   (i_data_r[47:40]),
    .mid        (m_calc)
  );

  // days to seconds, wraps modulo 2^32
  always_comb begin
    day_secs    = PW'(m_data_r.days) * PW'(bcde_pkg::SECS_PER_DAY);
    o_epoch_nxt = m_data_r.bad ? '0 : (EW'(day_secs) + EW'(m_data_r.tod));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_valid_r <= 1'b0;
      m_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      i_valid_r <= i_valid_nxt;
      m_valid_r <= m_valid_nxt;
      o_valid_r <= o_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (i_load) begin
      i_data_r <= in_tdata;
    end
    if (m_load) begin
      m_data_r <= m_calc;
    end
    if (o_load) begin
      o_epoch_r <= o_epoch_nxt;
      o_bad_r   <= m_data_r.bad;
    end
  end

  assign out_tvalid   = o_valid_r;
  assign out_tdata    = o_epoch_r;
  assign out_tuser[0] = o_bad_r;

endmodule

/* test/bcd_date_to_epoch_seconds_top_tb.sv */
// testbench for the bcd calendar date to epoch seconds converter
module bcd_date_to_epoch_seconds_top_tb;

  localparam int unsigned YEAR_BASE   = 68;
  localparam int unsigned EPOCH_YEAR  = 70;
  localparam int unsigned DAY_SECS    = 24 * 60 * 60;
  localparam int unsigned HOUR_SECS   = 3600;
  localparam int unsigned RANDOM_DATES = 400;
  localparam int unsigned IDLE_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 8;

  // days before the first of each month, common year
  localparam int unsigned DAYS_BEFORE [12] =
    '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

  // second ends up in the lowest byte, matching in_tdata
  typedef struct packed {
    logic [7:0] year;
    logic [7:0] month;
    logic [7:0] day;
    logic [7:0] hour;
    logic [7:0] minute;
    logic [7:0] second;
  } rtc_date_t;

  typedef struct packed {
    logic [31:0] seconds;
    logic        bad;
  } epoch_res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [0:0]  out_tuser;

  rtc_date_t   dates_to_send [$];
  epoch_res_t  due_results [$];
  int unsigned dates_accepted = 0;
  int unsigned dates_total = 0;
  int unsigned fail_count = 0;

  always #5 clk = ~clk;

  bcd_date_to_epoch_seconds_top #(
    .YEAR_BASE(YEAR_BASE)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  // two digits at face value, nibbles above nine included
  function automatic int unsigned digits(input logic [7:0] b);
    return int'(b[7:4]) * 10 + int'(b[3:0]);
  endfunction

  function automatic logic [7:0] to_bcd(input int unsigned n);
    logic [7:0] b;
    b[7:4] = 4'(n / 10);
    b[3:0] = 4'(n % 10);
    return b;
  endfunction

  function automatic rtc_date_t rtc_date(input int unsigned yr, input int unsigned mo,
                                         input int unsigned dy, input int unsigned hr,
                                         input int unsigned mi, input int unsigned sc);
    rtc_date_t d;
    d.year   = 8'(yr);
    d.month  = 8'(mo);
    d.day    = 8'(dy);
    d.hour   = 8'(hr);
    d.minute = 8'(mi);
    d.second = 8'(sc);
    return d;
  endfunction

  // calendar count with every fourth year a leap year, wraps at 32 bits
  function automatic epoch_res_t date_to_epoch(input rtc_date_t d);
    int unsigned     yr;
    int unsigned     mo;
    int unsigned     dy;
    longint unsigned days;
    longint unsigned total;
    epoch_res_t      r;
    yr = digits(d.year) + YEAR_BASE;
    mo = digits(d.month);
    dy = digits(d.day);
    r.seconds = '0;
    r.bad = 1'b1;
    if (yr < EPOCH_YEAR || mo < 1 || mo > 12 || dy < 1 || dy > 31) return r;
    // leap days from 1970 up to the start of this year
    days = longint'(365) * (yr - EPOCH_YEAR) + (yr - 1) / 4 - (EPOCH_YEAR - 1) / 4;
    days += DAYS_BEFORE[mo - 1] + dy - 1;
    if (yr % 4 == 0 && mo > 2) days += 1;
    total = days * DAY_SECS + longint'(digits(d.hour)) * HOUR_SECS
          + longint'(digits(d.minute)) * 60 + digits(d.second);
    r.seconds = total[31:0];
    r.bad = 1'b0;
    return r;
  endfunction

  // a well-formed date with decimal digits, year 1970 to 2067
  function automatic rtc_date_t random_good_date();
    return rtc_date(to_bcd($urandom_range(2, 99)), to_bcd($urandom_range(1, 12)),
                    to_bcd($urandom_range(1, 31)), to_bcd($urandom_range(0, 23)),
                    to_bcd($urandom_range(0, 59)), to_bcd($urandom_range(0, 59)));
  endfunction

  // driver: presents queued dates, random gap drawn per item
  always @(posedge clk) begin : date_driver
    int unsigned gap;
    bit          fast;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      gap = 0;
      fast = 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        due_results.push_back(date_to_epoch(rtc_date_t'(in_tdata)));
        dates_accepted++;
      end
      if (!in_tvalid || in_tready) begin
        if (gap != 0) begin
          gap--;
          in_tvalid <= 1'b0;
        end else if (dates_to_send.size() != 0) begin
          in_tdata <= dates_to_send.pop_front();
          in_tvalid <= 1'b1;
          // occasionally switch between back-to-back and gappy stretches
          if ($urandom_range(0, 29) == 0) fast = ~fast;
          gap = fast ? 0 : $urandom_range(0, 11);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each result against the oldest prediction, stalls at random
  always @(posedge clk) begin : result_monitor
    int unsigned stall;
    bit          fast;
    epoch_res_t  exp_res;
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall = 0;
      fast = 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (due_results.size() == 0) begin
          $display("%0t: result with no date pending: seconds %h bad %b",
                   $time, out_tdata, out_tuser);
          fail_count++;
        end else begin
          exp_res = due_results.pop_front();
          if (out_tdata !== exp_res.seconds) begin
            $display("%0t: epoch seconds expected %h got %h",
                     $time, exp_res.seconds, out_tdata);
            fail_count++;
          end
          if (out_tuser[0] !== exp_res.bad) begin
            $display("%0t: bad date flag expected %b got %b",
                     $time, exp_res.bad, out_tuser[0]);
            fail_count++;
          end
        end
        if ($urandom_range(0, 29) == 0) fast = ~fast;
        stall = fast ? 0 : $urandom_range(0, 11);
      end else if (stall != 0) begin
        stall--;
      end
      out_tready <= (stall == 0);
    end
  end

  // watchdog: too long without any item moving on either side
  always @(posedge clk) begin : watchdog
    int unsigned idle;
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle = 0;
    end else begin
      idle++;
      if (idle >= IDLE_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, idle);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int unsigned pick;
    rtc_date_t   d;

    // epoch start, 1970-01-01 00:00:00
    dates_to_send.push_back(rtc_date(8'h02, 8'h01, 8'h01, 8'h00, 8'h00, 8'h00));
    // last second of 1969 is rejected by the year check
    dates_to_send.push_back(rtc_date(8'h01, 8'h12, 8'h31, 8'h23, 8'h59, 8'h59));
    // month zero and month thirteen
    dates_to_send.push_back(rtc_date(8'h20, 8'h00, 8'h15, 8'h10, 8'h10, 8'h10));
    dates_to_send.push_back(rtc_date(8'h20, 8'h13, 8'h15, 8'h10, 8'h10, 8'h10));
    // day zero and day thirty-two
    dates_to_send.push_back(rtc_date(8'h20, 8'h06, 8'h00, 8'h10, 8'h10, 8'h10));
    dates_to_send.push_back(rtc_date(8'h20, 8'h06, 8'h32, 8'h10, 8'h10, 8'h10));
    // leap year 1972: end of february, leap day, first of march
    dates_to_send.push_back(rtc_date(8'h04, 8'h02, 8'h28, 8'h12, 8'h00, 8'h00));
    dates_to_send.push_back(rtc_date(8'h04, 8'h02, 8'h29, 8'h12, 8'h00, 8'h00));
    dates_to_send.push_back(rtc_date(8'h04, 8'h03, 8'h01, 8'h00, 8'h00, 8'h00));
    // day 31 in a 30-day month rolls into the next month
    dates_to_send.push_back(rtc_date(8'h30, 8'h04, 8'h31, 8'h00, 8'h00, 8'h00));
    // unchecked time of day, all nibbles at fifteen
    dates_to_send.push_back(rtc_date(8'h10, 8'h07, 8'h04, 8'hff, 8'hff, 8'hff));
    // non-decimal nibbles whose date fields still decode in range
    dates_to_send.push_back(rtc_date(8'h1f, 8'h0a, 8'h1c, 8'h0b, 8'h3e, 8'h5f));
    // month 0xa0 decodes to 100 and day 0xf0 to 150, both rejected
    dates_to_send.push_back(rtc_date(8'h40, 8'ha0, 8'h10, 8'h00, 8'h00, 8'h00));
    dates_to_send.push_back(rtc_date(8'h40, 8'h05, 8'hf0, 8'h00, 8'h00, 8'h00));
    // 2038 rollover of a signed count, still fine unsigned
    dates_to_send.push_back(rtc_date(8'h70, 8'h01, 8'h19, 8'h03, 8'h14, 8'h08));
    // largest year, 0xff decodes to 165, sum wraps past 32 bits
    dates_to_send.push_back(rtc_date(8'hff, 8'h12, 8'h31, 8'hff, 8'hff, 8'hff));
    dates_to_send.push_back(rtc_date(8'h99, 8'h12, 8'h31, 8'h23, 8'h59, 8'h59));
    // all zero and all ones
    dates_to_send.push_back(rtc_date(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    dates_to_send.push_back(rtc_date(8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff));

    for (int i = 0; i < RANDOM_DATES; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        d = random_good_date();
      end else if (pick < 80) begin
        // raw bytes: any nibble anywhere
        d = rtc_date_t'({$urandom, $urandom});
      end else if (pick < 90) begin
        // month and day in range, written with nibbles above nine where possible
        d = rtc_date($urandom_range(0, 255), $urandom_range(1, 12),
                     $urandom_range(1, 31), $urandom, $urandom, $urandom);
        if ($urandom_range(0, 1) != 0) d.month = 8'h0a + 8'($urandom_range(0, 2));
        if ($urandom_range(0, 1) != 0) d.day = 8'h0a + 8'($urandom_range(0, 5)) +
                                               (8'($urandom_range(0, 1)) << 4);
      end else begin
        // a good date with one broken field
        d = random_good_date();
        case ($urandom_range(0, 2))
          0:       d.year  = to_bcd($urandom_range(0, 1));
          1:       d.month = $urandom_range(0, 1) != 0 ? 8'h00 : 8'h13 + 8'($urandom_range(0, 236));
          default: d.day   = $urandom_range(0, 1) != 0 ? 8'h00 : 8'h32 + 8'($urandom_range(0, 205));
        endcase
      end
      dates_to_send.push_back(d);
    end
    dates_total = dates_to_send.size();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (dates_accepted < dates_total) @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    // let any stray result show up
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/bcde_pkg.sv
rtl/core/bcde_day_count.sv
rtl/core/bcd_date_to_epoch_seconds_top.sv
test/bcd_date_to_epoch_seconds_top_tb.sv
